// ===== rtl/vms_pkg.sv =====
// Shared constants, register indexes and types of the von Mises stress unit.
package vms_pkg;

	// Default values for the top level parameters.
	localparam int DEF_COMPONENT_WIDTH  = 24;
	localparam int DEF_FACTOR_FRAC_BITS = 16;

	// Fixed field widths of the register and result beats.
	localparam int FACTOR_WIDTH    = 17;
	localparam int TOL_WIDTH       = 24;
	localparam int EQ_WIDTH        = 25;
	localparam int RED_WIDTH       = 26;
	localparam int CFG_INDEX_WIDTH = 8;
	localparam int CFG_DATA_WIDTH  = 24;

	// Register indexes on the configuration channel.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_REDUCE_FACTOR = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHEAR_TOL     = CFG_INDEX_WIDTH'(1);

	// Register reset values.
	localparam logic [FACTOR_WIDTH-1:0] FACTOR_RESET = FACTOR_WIDTH'(65536);
	localparam logic [TOL_WIDTH-1:0]    TOL_RESET    = TOL_WIDTH'(1);

	// Control bits that travel with every pipeline stage.
	typedef struct packed {
		logic valid;
		logic is_diagonal;
	} ctl_t;

endpackage

// ===== rtl/vms_if.sv =====
// Channel interfaces of the von Mises stress unit: tensor input, result output, configuration.
interface vms_tensor_if #(
	parameter int COMPONENT_WIDTH = vms_pkg::DEF_COMPONENT_WIDTH
);
	logic                               valid;
	logic                               ready;
	logic signed [COMPONENT_WIDTH-1:0]  stress_xx;
	logic signed [COMPONENT_WIDTH-1:0]  stress_yy;
	logic signed [COMPONENT_WIDTH-1:0]  stress_zz;
	logic signed [COMPONENT_WIDTH-1:0]  shear_xy;
	logic signed [COMPONENT_WIDTH-1:0]  shear_yz;
	logic signed [COMPONENT_WIDTH-1:0]  shear_zx;

	modport source (
		output valid, stress_xx, stress_yy, stress_zz, shear_xy, shear_yz, shear_zx,
		input  ready
	);
	modport sink (
		input  valid, stress_xx, stress_yy, stress_zz, shear_xy, shear_yz, shear_zx,
		output ready
	);
endinterface

interface vms_result_if;
	logic                            valid;
	logic                            ready;
	logic [vms_pkg::EQ_WIDTH-1:0]    equivalent_stress;
	logic [vms_pkg::RED_WIDTH-1:0]   reduced_stress;
	logic                            is_diagonal;

	modport source (
		output valid, equivalent_stress, reduced_stress, is_diagonal,
		input  ready
	);
	modport sink (
		input  valid, equivalent_stress, reduced_stress, is_diagonal,
		output ready
	);
endinterface

interface vms_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [vms_pkg::CFG_INDEX_WIDTH-1:0]  index;
	logic [vms_pkg::CFG_DATA_WIDTH-1:0]   data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== rtl/vms_front.sv =====
// Front pipeline: differences and magnitudes, squares, partial sums and the weighted sum.
module vms_front #(
	parameter int COMPONENT_WIDTH = vms_pkg::DEF_COMPONENT_WIDTH,
	localparam int W  = COMPONENT_WIDTH,
	localparam int AW = 2 * COMPONENT_WIDTH + 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  logic [W-1:0]                    stress_xx,
	input  logic [W-1:0]                    stress_yy,
	input  logic [W-1:0]                    stress_zz,
	input  logic [W-1:0]                    shear_xy,
	input  logic [W-1:0]                    shear_yz,
	input  logic [W-1:0]                    shear_zx,
	input  logic [vms_pkg::TOL_WIDTH-1:0]   shear_tolerance,
	output logic [AW-1:0]                   acc,
	output vms_pkg::ctl_t                   ctl
);

	localparam int CW = (W > vms_pkg::TOL_WIDTH) ? W : vms_pkg::TOL_WIDTH;

	logic [W-1:0]   normal [3];
	logic [W-1:0]   shear [3];
	logic [W:0]     diff [3];
	logic [W-1:0]   dmag [3];
	logic [W-1:0]   smag [3];
	logic [2:0]     below;

	logic [W-1:0]    dmag_s1 [3];
	logic [W-1:0]    smag_s1 [3];
	vms_pkg::ctl_t   ctl_s1;
	logic [2*W-1:0]  dsq_s2 [3];
	logic [2*W-1:0]  ssq_s2 [3];
	vms_pkg::ctl_t   ctl_s2;
	logic [AW-1:0]   dsum_s3;
	logic [2*W-1:0]  ssum_s3;
	vms_pkg::ctl_t   ctl_s3;
	logic [AW-1:0]   acc_s4;
	vms_pkg::ctl_t   ctl_s4;

	assign normal[0] = stress_xx;
	assign normal[1] = stress_yy;
	assign normal[2] = stress_zz;
	assign shear[0]  = shear_xy;
	assign shear[1]  = shear_yz;
	assign shear[2]  = shear_zx;

	// Normal differences xx-yy, yy-zz, zz-xx and all magnitudes; a difference never
	// reaches 2^W in magnitude, so W bits hold it.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i]  = {normal[i][W-1], normal[i]} - {normal[(i+1)%3][W-1], normal[(i+1)%3]};
			dmag[i]  = diff[i][W] ? W'(~diff[i] + 1'b1) : diff[i][W-1:0];
			smag[i]  = shear[i][W-1] ? (~shear[i] + 1'b1) : shear[i];
			below[i] = CW'(smag[i]) < CW'(shear_tolerance);
		end
	end

	// Stage 1: magnitudes and the diagonal flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid       <= in_valid;
			ctl_s1.is_diagonal <= &below;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dmag_s1[i] <= dmag[i];
				smag_s1[i] <= smag[i];
			end
		end
	end

	// Stage 2: six squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dsq_s2[i] <= (2*W)'(dmag_s1[i]) * (2*W)'(dmag_s1[i]);
				ssq_s2[i] <= (2*W)'(smag_s1[i]) * (2*W)'(smag_s1[i]);
			end
		end
	end

	// Stage 3: sum of the squared differences and sum of the squared shears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dsum_s3 <= AW'(dsq_s2[0]) + AW'(dsq_s2[1]) + AW'(dsq_s2[2]);
			ssum_s3 <= ssq_s2[0] + ssq_s2[1] + ssq_s2[2];
		end
	end

	// Stage 4: half the difference sum plus three times the shear sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s4 <= (dsum_s3 >> 1) + AW'(ssum_s3) + (AW'(ssum_s3) << 1);
		end
	end

	assign acc = acc_s4;
	assign ctl = ctl_s4;

endmodule

// ===== rtl/vms_sqrt.sv =====
// Pipelined restoring square root: one root bit per stage.
module vms_sqrt #(
	parameter int COMPONENT_WIDTH = vms_pkg::DEF_COMPONENT_WIDTH,
	localparam int AW = 2 * COMPONENT_WIDTH + 2,
	localparam int RW = COMPONENT_WIDTH + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic [AW-1:0]   radicand,
	input  vms_pkg::ctl_t   ctl_in,
	output logic [RW-1:0]   root,
	output vms_pkg::ctl_t   ctl_out
);

	logic [AW-1:0]  rem_in [RW];
	logic [RW-1:0]  root_in [RW];
	vms_pkg::ctl_t  ctl_in_k [RW];

	logic [AW-1:0]  rem_s [RW];
	logic [RW-1:0]  root_s [RW];
	vms_pkg::ctl_t  ctl_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;

		logic [AW-1:0] trial;
		logic          take;

		// Stage inputs come from the radicand or from the previous stage.
		if (k == 0) begin : g_first
			assign rem_in[k]   = radicand;
			assign root_in[k]  = '0;
			assign ctl_in_k[k] = ctl_in;
		end else begin : g_next
			assign rem_in[k]   = rem_s[k-1];
			assign root_in[k]  = root_s[k-1];
			assign ctl_in_k[k] = ctl_s[k-1];
		end

		// Setting bit B grows the square by root*2^(B+1) + 2^(2B).
		assign trial = (AW'(root_in[k]) << (B + 1)) | (AW'(1) << (2 * B));
		assign take  = rem_in[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (adv) begin
				ctl_s[k] <= ctl_in_k[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= take ? (rem_in[k] - trial) : rem_in[k];
				root_s[k] <= take ? (root_in[k] | (RW'(1) << B)) : root_in[k];
			end
		end
	end

	assign root    = root_s[RW-1];
	assign ctl_out = ctl_s[RW-1];

`ifndef SYNTH
	// The final remainder of a floor square root never exceeds twice the root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[RW-1].valid |-> rem_s[RW-1] <= (AW'(root_s[RW-1]) << 1))
		else $error("square root remainder out of range");

	// After the top bit the remainder stays below the step to the next larger root.
	a_root_msb: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[0].valid |->
		(rem_s[0] < ((AW'(root_s[0]) << RW) + (AW'(1) << (2 * RW - 2)))))
		else $error("square root first stage remainder out of range");
`endif

endmodule

// ===== rtl/vms_scale.sv =====
// Output stage: scales the root by the reduce factor and holds the result beat.
module vms_scale #(
	parameter int COMPONENT_WIDTH  = vms_pkg::DEF_COMPONENT_WIDTH,
	parameter int FACTOR_FRAC_BITS = vms_pkg::DEF_FACTOR_FRAC_BITS,
	localparam int RW = COMPONENT_WIDTH + 1,
	localparam int PW = COMPONENT_WIDTH + 1 + vms_pkg::FACTOR_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic [RW-1:0]                      root,
	input  vms_pkg::ctl_t                      ctl_in,
	input  logic [vms_pkg::FACTOR_WIDTH-1:0]   reduce_factor_q16,
	output logic [vms_pkg::EQ_WIDTH-1:0]       equivalent_stress,
	output logic [vms_pkg::RED_WIDTH-1:0]      reduced_stress,
	output vms_pkg::ctl_t                      ctl_out
);

	logic [PW-1:0]                     product;
	logic [vms_pkg::EQ_WIDTH-1:0]      equiv_s1;
	logic [vms_pkg::RED_WIDTH-1:0]     reduced_s1;
	vms_pkg::ctl_t                     ctl_s1;

	// Full root times the Q factor, truncated by the fraction bits.
	assign product = PW'(root) * PW'(reduce_factor_q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			equiv_s1   <= vms_pkg::EQ_WIDTH'(root);
			reduced_s1 <= vms_pkg::RED_WIDTH'(product >> FACTOR_FRAC_BITS);
		end
	end

	assign equivalent_stress = equiv_s1;
	assign reduced_stress    = reduced_s1;
	assign ctl_out           = ctl_s1;

endmodule

// ===== rtl/von_mises_stress_unit_top.sv =====
// Top level of the von Mises stress unit: configuration registers and the stage chain.
//
// Takes one stress tensor beat per clock and returns floor(sqrt(m)) of the weighted
// sum m, that value scaled by the Q factor register, and a diagonal flag. There are
// four front stages for differences, squares and sums, one stage per root bit in the
// square root chain (COMPONENT_WIDTH + 1 stages), and the scaling stage that is also
// the output register. Throughput is one beat per cycle; the whole chain advances
// together, so while a result beat is held at the output the input is not ready.
// Registers are written through the configuration channel, which is always ready;
// write them only while no beat is in flight.
module von_mises_stress_unit_top #(
	parameter int COMPONENT_WIDTH  = vms_pkg::DEF_COMPONENT_WIDTH,
	parameter int FACTOR_FRAC_BITS = vms_pkg::DEF_FACTOR_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	vms_tensor_if.sink    tensor,
	vms_result_if.source  result,
	vms_cfg_if.sink       cfg
);

	localparam int AW = 2 * COMPONENT_WIDTH + 2;
	localparam int RW = COMPONENT_WIDTH + 1;

	logic [vms_pkg::FACTOR_WIDTH-1:0]  factor_q;
	logic [vms_pkg::TOL_WIDTH-1:0]     tol_q;
	logic                              adv;
	logic [AW-1:0]                     acc;
	vms_pkg::ctl_t                     front_ctl;
	logic [RW-1:0]                     root;
	vms_pkg::ctl_t                     root_ctl;
	vms_pkg::ctl_t                     out_ctl;

	// Configuration writes; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= vms_pkg::FACTOR_RESET;
			tol_q    <= vms_pkg::TOL_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				vms_pkg::REG_REDUCE_FACTOR: factor_q <= cfg.data[vms_pkg::FACTOR_WIDTH-1:0];
				vms_pkg::REG_SHEAR_TOL:     tol_q    <= cfg.data[vms_pkg::TOL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// The chain moves when the output register is empty or its beat is taken.
	assign adv          = !out_ctl.valid || result.ready;
	assign tensor.ready = adv;

	vms_front #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.in_valid        (tensor.valid),
		.stress_xx       (tensor.stress_xx),
		.stress_yy       (tensor.stress_yy),
		.stress_zz       (tensor.stress_zz),
		.shear_xy        (tensor.shear_xy),
		.shear_yz        (tensor.shear_yz),
		.shear_zx        (tensor.shear_zx),
		.shear_tolerance (tol_q),
		.acc             (acc),
		.ctl             (front_ctl)
	);

	vms_sqrt #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.radicand (acc),
		.ctl_in   (front_ctl),
		.root     (root),
		.ctl_out  (root_ctl)
	);

	vms_scale #(
		.COMPONENT_WIDTH  (COMPONENT_WIDTH),
		.FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
	) u_scale (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.root              (root),
		.ctl_in            (root_ctl),
		.reduce_factor_q16 (factor_q),
		.equivalent_stress (result.equivalent_stress),
		.reduced_stress    (result.reduced_stress),
		.ctl_out           (out_ctl)
	);

	assign result.valid       = out_ctl.valid;
	assign result.is_diagonal = out_ctl.is_diagonal;

`ifndef SYNTH
	// With a zero tolerance no shear magnitude is below it.
	a_zero_tol: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (tol_q == '0)) |-> !result.is_diagonal)
		else $error("diagonal flag set with zero tolerance");

	// A unit factor passes the root through to the reduced value.
	a_unit_factor: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (64'(factor_q) == (64'(1) << FACTOR_FRAC_BITS))) |->
		(result.reduced_stress[vms_pkg::EQ_WIDTH-1:0] == result.equivalent_stress))
		else $error("reduced value differs from root under unit factor");
`endif

endmodule

// ===== tb/sv/vms_tb_pkg.sv =====
// Test types, constants and the result scoreboard of the von Mises stress unit bench.
`timescale 1ns / 1ps
package vms_tb_pkg;
	import vms_pkg::*;

	localparam int CW          = DEF_COMPONENT_WIDTH;
	localparam int FACTOR_FRAC = DEF_FACTOR_FRAC_BITS;

	// Register indexes that the block must ignore.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED    = REG_SHEAR_TOL + CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INDEX_TOP = {CFG_INDEX_WIDTH{1'b1}};

	// Component values used by the directed tensors.
	localparam logic signed [CW-1:0] COMP_MAX  = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COMP_MIN  = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] COMP_ZERO = '0;
	localparam logic signed [CW-1:0] COMP_ONE  = CW'(1);
	localparam logic signed [CW-1:0] COMP_NEG1 = '1;

	typedef struct packed {
		logic signed [CW-1:0] stress_xx;
		logic signed [CW-1:0] stress_yy;
		logic signed [CW-1:0] stress_zz;
		logic signed [CW-1:0] shear_xy;
		logic signed [CW-1:0] shear_yz;
		logic signed [CW-1:0] shear_zx;
	} tensor_t;

	typedef struct packed {
		logic [EQ_WIDTH-1:0]  equivalent_stress;
		logic [RED_WIDTH-1:0] reduced_stress;
		logic                 is_diagonal;
	} stress_result_t;

	// Keeps a private copy of the registers, predicts each tensor and checks result beats.
	class vms_scoreboard;
		logic [FACTOR_WIDTH-1:0] reduce_factor;
		logic [TOL_WIDTH-1:0]    shear_limit;
		stress_result_t          stress_due[$];
		int unsigned             mismatches;
		int unsigned             checked;
		int unsigned             noted;
		int unsigned             writes;

		function new();
			reduce_factor = FACTOR_RESET;
			shear_limit   = TOL_RESET;
			mismatches    = 0;
			checked       = 0;
			noted         = 0;
			writes        = 0;
		endfunction

		// Mirror a register write; unknown indexes and bits above the field are dropped.
		function void write_register(logic [CFG_INDEX_WIDTH-1:0] index,
				logic [CFG_DATA_WIDTH-1:0] data);
			writes++;
			case (index)
				REG_REDUCE_FACTOR: reduce_factor = data[FACTOR_WIDTH-1:0];
				REG_SHEAR_TOL:     shear_limit = data[TOL_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		// Exact integer von Mises stress, scaled value and diagonal flag of one tensor.
		function stress_result_t predict_stress(tensor_t t);
			stress_result_t      r;
			longint              xx, yy, zz, d, shear_mag;
			longint              shear[3];
			longint unsigned     half_sum, root, probe, scaled;
			logic                diag;
			xx = t.stress_xx;
			yy = t.stress_yy;
			zz = t.stress_zz;
			shear[0] = t.shear_xy;
			shear[1] = t.shear_yz;
			shear[2] = t.shear_zx;
			half_sum = 0;
			d = xx - yy;
			half_sum += d * d;
			d = yy - zz;
			half_sum += d * d;
			d = zz - xx;
			half_sum += d * d;
			// The sum of the squared differences is always even.
			half_sum = half_sum >> 1;
			diag = 1'b1;
			for (int i = 0; i < 3; i++) begin
				shear_mag = (shear[i] < 0) ? -shear[i] : shear[i];
				half_sum += 3 * shear_mag * shear_mag;
				if (shear_mag >= shear_limit)
					diag = 1'b0;
			end
			// Digit by digit floor square root.
			root  = 0;
			probe = 64'd1 << 62;
			while (probe > half_sum)
				probe = probe >> 2;
			while (probe != 0) begin
				if (half_sum >= root + probe) begin
					half_sum = half_sum - (root + probe);
					root = (root >> 1) + probe;
				end else begin
					root = root >> 1;
				end
				probe = probe >> 2;
			end
			scaled = (root * reduce_factor) >> FACTOR_FRAC;
			r.equivalent_stress = root[EQ_WIDTH-1:0];
			r.reduced_stress    = scaled[RED_WIDTH-1:0];
			r.is_diagonal       = diag;
			return r;
		endfunction

		function void note_tensor(tensor_t t);
			stress_due.push_back(predict_stress(t));
			noted++;
		endfunction

		function int pending();
			return stress_due.size();
		endfunction

		// Compare one result beat with the oldest outstanding prediction.
		function void check_result(logic [EQ_WIDTH-1:0] eq, logic [RED_WIDTH-1:0] red,
				logic diag);
			stress_result_t want;
			if (stress_due.size() == 0) begin
				$error("result beat arrived with no tensor outstanding");
				mismatches++;
				return;
			end
			want = stress_due.pop_front();
			checked++;
			if (eq !== want.equivalent_stress) begin
				$error("equivalent_stress: expected %0d, got %0d", want.equivalent_stress, eq);
				mismatches++;
			end
			if (red !== want.reduced_stress) begin
				$error("reduced_stress: expected %0d, got %0d", want.reduced_stress, red);
				mismatches++;
			end
			if (diag !== want.is_diagonal) begin
				$error("is_diagonal: expected %0d, got %0d", want.is_diagonal, diag);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_von_mises_stress_unit_top.sv =====
// Bench top for the von Mises stress unit: directed and random tensors, register sweeps, backpressure.
`timescale 1ns / 1ps
module tb_von_mises_stress_unit_top;
	import vms_pkg::*;
	import vms_tb_pkg::*;

	localparam int LATENCY       = CW + 6;
	localparam int LONG_HOLD     = 240;
	localparam int PHASES        = 6;
	localparam int PHASE_TENSORS = 315;

	logic          clk;
	logic          arst_n;
	int unsigned   hold_requests = 0;
	int unsigned   holds_served = 0;
	vms_scoreboard stress_board = new();

	vms_tensor_if #(.COMPONENT_WIDTH(CW)) tensor_ch();
	vms_result_if                         result_ch();
	vms_cfg_if                            cfg_ch();

	von_mises_stress_unit_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.tensor (tensor_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog for a hung or dropping pipeline.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// Check every accepted result beat.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			stress_board.check_result(result_ch.equivalent_stress, result_ch.reduced_stress,
				result_ch.is_diagonal);
	end

	// Output ready pattern: spans of no, light and heavy stalling, plus requested long holds.
	initial begin
		int mode;
		int span;
		result_ch.ready <= 1'b0;
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(8, 96);
				repeat (span) begin
					if (hold_requests != holds_served)
						break;
					case (mode)
						0: result_ch.ready <= 1'b1;
						1: result_ch.ready <= ($urandom_range(0, 3) != 0);
						default: result_ch.ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Offer one tensor beat and wait until it is taken.
	task automatic send_tensor(input tensor_t t);
		tensor_ch.valid     <= 1'b1;
		tensor_ch.stress_xx <= t.stress_xx;
		tensor_ch.stress_yy <= t.stress_yy;
		tensor_ch.stress_zz <= t.stress_zz;
		tensor_ch.shear_xy  <= t.shear_xy;
		tensor_ch.shear_yz  <= t.shear_yz;
		tensor_ch.shear_zx  <= t.shear_zx;
		do @(posedge clk); while (!tensor_ch.ready);
		stress_board.note_tensor(t);
	endtask

	// One register write beat, after which the channel idles before the task returns.
	task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
			input logic [CFG_DATA_WIDTH-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		stress_board.write_register(index, data);
		@(posedge clk);
	endtask

	task automatic idle_gap(input int cycles);
		tensor_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Wait for every outstanding result, then let the pipeline settle.
	task automatic drain();
		tensor_ch.valid <= 1'b0;
		while (stress_board.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] any_value();
		return CW'($urandom());
	endfunction

	function automatic logic signed [CW-1:0] small_value();
		return CW'($urandom_range(0, 32)) - CW'(16);
	endfunction

	function automatic logic signed [CW-1:0] extreme_value();
		case ($urandom_range(0, 4))
			0: return COMP_MAX;
			1: return COMP_MIN;
			2: return COMP_ONE;
			3: return COMP_NEG1;
			default: return COMP_ZERO;
		endcase
	endfunction

	// A shear whose magnitude sits one below, at, or one above the tolerance.
	function automatic logic signed [CW-1:0] near_limit(input logic [TOL_WIDTH-1:0] tol);
		logic [CW:0] mag;
		mag = (CW+1)'(tol + $urandom_range(0, 2) - 1);
		return ($urandom_range(0, 1) == 1) ? -mag[CW-1:0] : mag[CW-1:0];
	endfunction

	// Random tensor drawn from a mix of wide, small, near-hydrostatic and edge styles.
	function automatic tensor_t random_tensor(input logic [TOL_WIDTH-1:0] tol);
		tensor_t                t;
		logic signed [CW-1:0]   base;
		case ($urandom_range(0, 9))
			5: t = '{small_value(), small_value(), small_value(),
				small_value(), small_value(), small_value()};
			6: begin
				base = any_value();
				t = '{base + small_value(), base + small_value(), base,
					small_value(), small_value(), small_value()};
			end
			7: t = '{extreme_value(), extreme_value(), extreme_value(),
				extreme_value(), extreme_value(), extreme_value()};
			8: t = '{any_value(), any_value(), any_value(),
				near_limit(tol), near_limit(tol), near_limit(tol)};
			9: t = '{small_value(), small_value(), small_value(),
				any_value(), any_value(), any_value()};
			default: t = '{any_value(), any_value(), any_value(),
				any_value(), any_value(), any_value()};
		endcase
		return t;
	endfunction

	// Main stimulus.
	initial begin
		int                          burst_left;
		int                          gap;
		int                          pick;
		logic [FACTOR_WIDTH-1:0]     factor;
		logic [TOL_WIDTH-1:0]        tol;
		logic                        ok;

		arst_n              <= 1'b0;
		tensor_ch.valid     <= 1'b0;
		tensor_ch.stress_xx <= '0;
		tensor_ch.stress_yy <= '0;
		tensor_ch.stress_zz <= '0;
		tensor_ch.shear_xy  <= '0;
		tensor_ch.shear_yz  <= '0;
		tensor_ch.shear_zx  <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= '0;
		cfg_ch.data         <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: unit factor, tolerance of one.
		send_tensor('{COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		send_tensor('{COMP_MAX, COMP_MIN, COMP_MAX, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		send_tensor('{COMP_MIN, COMP_MAX, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		send_tensor('{COMP_MAX, COMP_MAX, COMP_MAX, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		send_tensor('{COMP_MIN, COMP_MIN, COMP_MIN, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		send_tensor('{COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ONE, COMP_ZERO, COMP_ZERO});
		send_tensor('{COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_NEG1, COMP_ZERO});
		send_tensor('{COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_MIN});
		send_tensor('{COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_MAX, COMP_MAX, COMP_MAX});
		send_tensor('{COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MIN, COMP_MIN});
		send_tensor('{COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX});
		send_tensor('{COMP_NEG1, COMP_ONE, COMP_ZERO, COMP_ONE, COMP_NEG1, COMP_ONE});
		drain();

		// Zero factor and zero tolerance: nothing is ever diagonal.
		write_register(REG_REDUCE_FACTOR, '0);
		write_register(REG_SHEAR_TOL, '0);
		send_tensor('{COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		send_tensor('{COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MIN, COMP_MIN});
		send_tensor('{COMP_ONE, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		drain();

		// Largest factor written with spare high bits, tolerance 2^(CW-1), ignored indexes.
		write_register(REG_REDUCE_FACTOR, '1);
		write_register(REG_SHEAR_TOL, CFG_DATA_WIDTH'(1) << (CW - 1));
		write_register(REG_UNUSED, '0);
		write_register(REG_INDEX_TOP, '0);
		send_tensor('{COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MIN, COMP_MIN});
		send_tensor('{COMP_MAX, COMP_MIN, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX});
		send_tensor('{COMP_MIN, COMP_MAX, COMP_ZERO, COMP_MAX, COMP_MIN, COMP_MAX});
		send_tensor('{COMP_ONE, COMP_NEG1, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		send_tensor('{COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO});
		drain();

		// Random phases, each with its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 3))
				0: factor = '0;
				1: factor = '1;
				2: factor = FACTOR_RESET;
				default: factor = FACTOR_WIDTH'($urandom());
			endcase
			case ($urandom_range(0, 4))
				0: tol = '0;
				1: tol = TOL_RESET;
				2: tol = TOL_WIDTH'(1) << (CW - 1);
				3: tol = TOL_WIDTH'($urandom_range(1, 4096));
				default: tol = TOL_WIDTH'($urandom_range(0, 8388608));
			endcase
			write_register(REG_REDUCE_FACTOR,
				{CFG_DATA_WIDTH'($urandom()) >> FACTOR_WIDTH << FACTOR_WIDTH} | factor);
			write_register(REG_SHEAR_TOL, tol);
			if ($urandom_range(0, 1) == 1)
				write_register(REG_UNUSED + CFG_INDEX_WIDTH'($urandom_range(0, 200)),
					CFG_DATA_WIDTH'($urandom()));

			burst_left = $urandom_range(1, 40);
			for (int n = 0; n < PHASE_TENSORS; n++) begin
				// Hold the output for a long stretch while beats keep coming.
				if (n == 0 && (p == 1 || p == 4)) begin
					hold_requests <= hold_requests + 1;
					burst_left = 120;
				end
				send_tensor(random_tensor(stress_board.shear_limit));
				burst_left--;
				if (burst_left <= 0) begin
					pick = $urandom_range(0, 9);
					if (pick < 3)
						gap = 0;
					else if (pick < 9)
						gap = $urandom_range(1, 8);
					else
						gap = $urandom_range(20, 60);
					if (gap > 0)
						idle_gap(gap);
					burst_left = $urandom_range(1, 40);
				end
			end
			drain();
		end

		$display("Sent %0d tensors and checked %0d result beats over %0d register writes.",
			stress_board.noted, stress_board.checked, stress_board.writes);
		$display("%s %0d long output holds.",
			"Register sweeps included zero and full-scale factors and tolerances;",
			holds_served);
		ok = (stress_board.mismatches == 0) && (stress_board.pending() == 0);
		if (ok)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/vms_pkg.sv
rtl/vms_if.sv
rtl/vms_front.sv
rtl/vms_sqrt.sv
rtl/vms_scale.sv
rtl/von_mises_stress_unit_top.sv
tb/sv/vms_tb_pkg.sv
tb/sv/tb_von_mises_stress_unit_top.sv
